// ----- rtl/core/utg_pkg.sv -----
// utg_pkg: shared types, width constants and glyph lookup for the
// utf-8 to glyph decoder. no dependencies.
`default_nettype none

package utg_pkg;

   localparam int CpWidth    = 21;
   localparam int GlyphWidth = 8;
   localparam int ByteWidth  = 8;

   localparam logic [GlyphWidth-1:0] UnmappedGlyph = 8'h7F;

   // one decoded result
   typedef struct packed {
      logic [CpWidth-1:0]    code_point;
      logic [GlyphWidth-1:0] glyph_index;
      logic                  last_of_run;
   } result_type;

   // what one byte produces: 0, 1 or 2 results, in order
   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } decode_type;

   function automatic logic [GlyphWidth-1:0] glyph_lookup(input logic [CpWidth-1:0] cp);
      logic [GlyphWidth-1:0] g;
      g = UnmappedGlyph;
      if (cp < 21'h80) begin
         g = cp[GlyphWidth-1:0];
      end else begin
         case (cp) inside
            21'hA7, 21'hC1, 21'hC9, 21'hCD, 21'hD3, 21'hD6, 21'hDA, 21'hDC,
            21'hE1, 21'hE9, 21'hED, 21'hF3, 21'hF6, 21'hFA, 21'hFC: begin
               g = cp[GlyphWidth-1:0];
            end
            21'h150:                    g = 8'hD5;
            21'h151:                    g = 8'hF5;
            21'h170:                    g = 8'hDB;
            21'h171:                    g = 8'hFB;
            21'h2013, 21'h2014:         g = 8'h2D;
            21'h2018, 21'h2019:         g = 8'h27;
            21'h201C, 21'h201D, 21'h201E: g = 8'h22;
            21'h2026:                   g = 8'h2E;
            21'hA0:                     g = 8'h20;
            default:                    g = UnmappedGlyph;
         endcase
      end
      return g;
   endfunction

   function automatic result_type make_result(input logic [CpWidth-1:0] cp,
                                              input logic last);
      result_type r;
      r.code_point  = cp;
      r.glyph_index = glyph_lookup(cp);
      r.last_of_run = last;
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/core/utg_decode.sv -----
// utg_decode: sequence state (pending count, accumulator) and per-byte decode.
// depends on utg_pkg.
`default_nettype none

module utg_decode (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [utg_pkg::ByteWidth-1:0] text_byte,
   input  wire logic                          advance,
   output utg_pkg::decode_type                dec
);

   logic [1:0]                      pending_ff, pending_in;
   logic [utg_pkg::CpWidth-1:0]     acc_ff, acc_in;

   logic                            is_cont;
   logic                            flush;
   logic                            own_emit;
   logic [utg_pkg::CpWidth-1:0]     own_cp;
   logic [utg_pkg::CpWidth-1:0]     shifted;

   assign is_cont = (text_byte[7:6] == 2'b10);
   assign shifted = {acc_ff[utg_pkg::CpWidth-7:0], text_byte[5:0]};

   always_comb begin
      pending_in = pending_ff;
      acc_in     = acc_ff;
      flush      = 1'b0;
      own_emit   = 1'b0;
      own_cp     = '0;
      dec        = '0;
      if (pending_ff != 2'd0 && is_cont) begin
         acc_in     = shifted;
         pending_in = pending_ff - 2'd1;
         if (pending_ff == 2'd1) begin
            dec.count = 2'd1;
            dec.first = utg_pkg::make_result(shifted, 1'b1);
         end
      end else begin
         flush      = (pending_ff != 2'd0);
         pending_in = 2'd0;
         acc_in     = '0;
         if (text_byte == 8'h00) begin
            own_emit = 1'b0;
         end else if (text_byte[7] == 1'b0) begin
            own_emit = 1'b1;
            own_cp   = {13'd0, text_byte};
         end else if (text_byte[7:5] == 3'b110) begin
            pending_in = 2'd1;
            acc_in     = {16'd0, text_byte[4:0]};
         end else if (text_byte[7:4] == 4'b1110) begin
            pending_in = 2'd2;
            acc_in     = {17'd0, text_byte[3:0]};
         end else if (text_byte[7:3] == 5'b11110) begin
            pending_in = 2'd3;
            acc_in     = {18'd0, text_byte[2:0]};
         end else begin
            // stray continuation or invalid lead: low six bits at once
            own_emit = 1'b1;
            own_cp   = {15'd0, text_byte[5:0]};
         end
         if (flush) begin
            dec.first = utg_pkg::make_result(acc_ff, !own_emit);
            dec.second = utg_pkg::make_result(own_cp, 1'b1);
            dec.count = own_emit ? 2'd2 : 2'd1;
         end else if (own_emit) begin
            dec.first = utg_pkg::make_result(own_cp, 1'b1);
            dec.count = 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 2'd0;
         acc_ff     <= '0;
      end else if (advance) begin
         pending_ff <= pending_in;
         acc_ff     <= acc_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/utg_out_buffer.sv -----
// utg_out_buffer: two-slot result register, takes up to two items a cycle
// and hands out one. depends on utg_pkg.
`default_nettype none

module utg_out_buffer (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   input  wire utg_pkg::decode_type dec,
   input  wire logic        pop_ready,
   output logic [1:0]       space,
   output logic             head_valid,
   output utg_pkg::result_type head
);

   utg_pkg::result_type slot0_ff, slot0_in, slot1_ff, slot1_in;
   logic [1:0]          count_ff, count_in;
   logic                pop;
   logic [1:0]          kept;
   logic [1:0]          added;

   assign head_valid = (count_ff != 2'd0);
   assign head       = slot0_ff;
   assign pop        = head_valid && pop_ready;
   assign kept       = count_ff - {1'b0, pop};
   assign space      = 2'd2 - kept;
   assign added      = push ? dec.count : 2'd0;

   always_comb begin
      slot0_in = pop ? slot1_ff : slot0_ff;
      slot1_in = slot1_ff;
      case (kept)
         2'd0: begin
            slot0_in = dec.first;
            slot1_in = dec.second;
         end
         2'd1: begin
            slot1_in = dec.first;
         end
         default: begin
            slot1_in = slot1_ff;
         end
      endcase
      count_in = kept + added;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

endmodule

`default_nettype wire

// ----- rtl/core/utf8_to_glyph_decoder.sv -----
// utf8_to_glyph_decoder: lenient utf-8 byte stream to code point and glyph index.
// the accepted byte is registered in s1, decoded, then registered in the result buffer.
// throughput: one byte per cycle while its results fit the two-slot result register
// after this cycle's pop; a byte giving two results waits until that register is empty.
// reset: synchronous, clears the open sequence and drops buffered results.
// depends on utg_pkg, utg_decode, utg_out_buffer.
`default_nettype none

module utf8_to_glyph_decoder (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] text_byte
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // [20:0] code_point, [28:21] glyph_index, zeros
   output logic             rsp_tlast    // last_of_run
);

   logic                s1_valid_ff, s1_valid_in;
   logic [7:0]          s1_byte_ff;
   logic                s1_fire;
   logic                req_fire;
   logic [1:0]          space;
   utg_pkg::decode_type dec;
   utg_pkg::result_type head;

   utg_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .text_byte (s1_byte_ff),
      .advance   (s1_fire),
      .dec       (dec)
   );

   utg_out_buffer u_out (
      .clock      (clock),
      .reset      (reset),
      .push       (s1_fire),
      .dec        (dec),
      .pop_ready  (rsp_tready),
      .space      (space),
      .head_valid (rsp_tvalid),
      .head       (head)
   );

   // the byte moves on only if its results fit after this cycle's pop
   assign s1_fire     = s1_valid_ff && (dec.count <= space);
   assign req_tready  = !s1_valid_ff || s1_fire;
   assign req_fire    = req_tvalid && req_tready;
   assign s1_valid_in = req_fire || (s1_valid_ff && !s1_fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_byte_ff <= req_tdata;
      end
   end

   assign rsp_tdata = {3'd0, head.glyph_index, head.code_point};
   assign rsp_tlast = head.last_of_run;

   a_space_range: assert property (@(posedge clock) disable iff (reset)
      space <= 2'd2) else $error("result buffer over full");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_fire |=> s1_valid_ff && $stable(s1_byte_ff))
      else $error("stalled byte lost or changed");

   a_two_last: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && dec.count == 2'd2 |-> !dec.first.last_of_run && dec.second.last_of_run)
      else $error("last flag misplaced on a two-result byte");

   a_one_last: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && dec.count == 2'd1 |-> dec.first.last_of_run)
      else $error("single result without last flag");

endmodule

`default_nettype wire
